// ===== hdl/sbp_pkg.sv =====
// Types and fixed constants shared by the stereo sample bit packer.
package sbp_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WORD_BITS   = 16;
    localparam int FILL_BITS   = 4;
    localparam int WIDTH_BITS  = 5;
    localparam int MAX_RESULTS = 3;
    localparam int CNT_BITS    = 2;
    localparam int STREAM_BITS = MAX_RESULTS * WORD_BITS;
    localparam int TOTAL_BITS  = 6;

    localparam logic [WIDTH_BITS-1:0] WIDTH_MIN   = 5'd1;
    localparam logic [WIDTH_BITS-1:0] WIDTH_MAX   = 5'd16;
    localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 5'd16;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left_sample;
        logic [SAMPLE_BITS-1:0] right_sample;
        logic                   last;
    } in_item_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] packed_word;
        logic                 run_last;
        logic                 stream_end;
    } out_item_t;

    // Words produced by one request; the final one is the flush word when flush is set.
    typedef struct packed {
        logic [CNT_BITS-1:0]                    count;
        logic [MAX_RESULTS-1:0][WORD_BITS-1:0]  words;
        logic                                   flush;
    } pack_res_t;

    function automatic logic [WIDTH_BITS-1:0] clamp_width(input logic [WIDTH_BITS-1:0] v);
        logic [WIDTH_BITS-1:0] w;
        w = v;
        if (v < WIDTH_MIN)
            w = WIDTH_MIN;
        else if (v > WIDTH_MAX)
            w = WIDTH_MAX;
        return w;
    endfunction

endpackage

// ===== hdl/sbp_pack.sv =====
// Packing datapath: accumulator state and the single-pass merge of one sample pair.
module sbp_pack import sbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  in_item_t              item,
    input  logic [WIDTH_BITS-1:0] width,
    output pack_res_t             res
);

    logic [WORD_BITS-1:0]   acc_reg,  acc_next;
    logic [FILL_BITS-1:0]   fill_reg, fill_next;

    logic [SAMPLE_BITS-1:0] keep_mask;
    logic [SAMPLE_BITS-1:0] left_kept;
    logic [SAMPLE_BITS-1:0] right_kept;
    logic [TOTAL_BITS-1:0]  right_shift;
    logic [TOTAL_BITS-1:0]  total;
    logic [STREAM_BITS-1:0] stream;
    logic [CNT_BITS-1:0]    n_full;
    logic [FILL_BITS-1:0]   rest;
    logic [WORD_BITS-1:0]   tail;
    logic                   flush;

    // The accumulator is kept left-aligned, unused low bits zero.
    always_comb
    begin
        keep_mask   = ~({SAMPLE_BITS{1'b1}} >> width);
        left_kept   = item.left_sample  & keep_mask;
        right_kept  = item.right_sample & keep_mask;
        right_shift = TOTAL_BITS'(fill_reg) + TOTAL_BITS'(width);
        total       = right_shift + TOTAL_BITS'(width);
        stream      = {acc_reg, {(STREAM_BITS-WORD_BITS){1'b0}}}
                    | ({left_kept,  {(STREAM_BITS-SAMPLE_BITS){1'b0}}} >> fill_reg)
                    | ({right_kept, {(STREAM_BITS-SAMPLE_BITS){1'b0}}} >> right_shift);
        n_full      = total[TOTAL_BITS-1:FILL_BITS];
        rest        = total[FILL_BITS-1:0];

        case (n_full)
            2'd0:    tail = stream[3*WORD_BITS-1:2*WORD_BITS];
            2'd1:    tail = stream[2*WORD_BITS-1:WORD_BITS];
            default: tail = stream[WORD_BITS-1:0];
        endcase

        flush = item.last && (rest != '0);

        res.words[0] = stream[3*WORD_BITS-1:2*WORD_BITS];
        res.words[1] = stream[2*WORD_BITS-1:WORD_BITS];
        res.words[2] = stream[WORD_BITS-1:0];
        res.count    = n_full + CNT_BITS'(flush);
        res.flush    = flush;

        if (item.last)
        begin
            acc_next  = '0;
            fill_next = '0;
        end
        else
        begin
            acc_next  = tail;
            fill_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            fill_reg <= '0;
        end
        else if (step)
        begin
            acc_reg  <= acc_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== hdl/sbp_out_buf.sv =====
// Result buffer: holds the words of one request and hands them out one per cycle while out_ready is high.
module sbp_out_buf import sbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  pack_res_t res,
    output logic      free,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic [MAX_RESULTS-1:0][WORD_BITS-1:0] words_reg;
    logic [CNT_BITS-1:0]                   cnt_reg;
    logic [CNT_BITS-1:0]                   idx_reg;
    logic                                  flush_reg;
    logic                                  valid_reg;
    logic                                  last_beat;
    logic                                  out_fire;

    assign last_beat = (idx_reg == (cnt_reg - CNT_BITS'(1)));
    assign out_fire  = valid_reg && out_ready;
    assign free      = !valid_reg || (out_ready && last_beat);
    assign out_valid = valid_reg;

    assign out_data.packed_word = words_reg[idx_reg];
    assign out_data.run_last    = last_beat;
    assign out_data.stream_end  = flush_reg && last_beat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            if (out_fire)
            begin
                if (last_beat)
                    valid_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + CNT_BITS'(1);
            end
            // load only arrives when the buffer is free, so it overrides the drain
            if (load && (res.count != '0))
            begin
                valid_reg <= 1'b1;
                cnt_reg   <= res.count;
                idx_reg   <= '0;
                flush_reg <= res.flush;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            words_reg <= res.words;
    end

endmodule

// ===== hdl/stereo_sample_bit_packer.sv =====
// Top level: input register, width register, packing datapath and result buffer.
// A request accepted into the input register moves into the result buffer as soon as
// the buffer is free, and its first word then goes on the output.
// Throughput: one request per cycle while each gives at most one word and out_ready
// is high; a multi-word request holds the port until all are taken (two at full width).
// Reset (rst_n low, asynchronous): accumulator and fill count cleared, width set to
// sixteen, input and result registers emptied.
module stereo_sample_bit_packer import sbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [WIDTH_BITS-1:0] cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data
);

    logic [WIDTH_BITS-1:0] width_reg;
    logic                  s1_valid_reg;
    in_item_t              s1_item_reg;
    logic                  buf_free;
    logic                  s1_fire;
    pack_res_t             pack_res;

    assign s1_fire  = s1_valid_reg && buf_free;
    assign in_ready = !s1_valid_reg || buf_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RESET;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                width_reg <= clamp_width(cfg_wr_data);
            if (in_valid && in_ready)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_item_reg <= in_data;
    end

    sbp_pack u_pack (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (s1_fire),
        .item  (s1_item_reg),
        .width (width_reg),
        .res   (pack_res)
    );

    sbp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_fire),
        .res       (pack_res),
        .free      (buf_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== hdl/sbp_checker.sv =====
// Port-level checks for the stereo sample bit packer, bound to the top level.
module sbp_checker import sbp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("stalled result changed");

    // the flush word always closes its request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.stream_end |-> out_data.run_last)
        else $error("stream end on a word that is not the last of its request");

    // a request's remaining words follow without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.run_last |=> out_valid)
        else $error("gap inside the words of one request");

    // an empty result buffer never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

endmodule

bind stereo_sample_bit_packer sbp_checker u_sbp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/stereo_sample_bit_packer_tb.sv =====
// Self-checking testbench for the stereo sample bit packer: directed table, then random phases.
module stereo_sample_bit_packer_tb;
    import sbp_pkg::*;

    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 13;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 6;
    localparam int REPORT_LIMIT   = 10;
    localparam int HEAVY_IDLE_PCT = 67;
    localparam int BOTH_IDLE_PCT  = 21;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // One directed request: optional width write first, then the pair. Where typed is set,
    // the first n_typed words of want (slot 0 in the low bits) are the expected results.
    typedef struct packed {
        logic                              wr;
        logic [WIDTH_BITS-1:0]             width;
        in_item_t                          item;
        logic                              typed;
        logic [1:0]                        n_typed;
        out_item_t [MAX_RESULTS-1:0]       want;
    } pair_case_t;

    // want slots are {packed_word, run_last, stream_end}, listed slot 2, slot 1, slot 0
    localparam pair_case_t PAIR_CASES [22] = '{
        '{1'b0, 5'd16, {16'hFFFF, 16'h0000, 1'b0}, 1'b1, 2'd2,
          {18'h0, {16'h0000, 2'b10}, {16'hFFFF, 2'b00}}},
        '{1'b0, 5'd16, {16'h1234, 16'hABCD, 1'b1}, 1'b1, 2'd2,
          {18'h0, {16'hABCD, 2'b10}, {16'h1234, 2'b00}}},
        '{1'b1, 5'd1,  {16'h8000, 16'h7FFF, 1'b1}, 1'b1, 2'd1,
          {18'h0, 18'h0, {16'h8000, 2'b11}}},
        '{1'b1, 5'd0,  {16'hFFFF, 16'hFFFF, 1'b1}, 1'b1, 2'd1,
          {18'h0, 18'h0, {16'hC000, 2'b11}}},
        '{1'b1, 5'd31, {16'hAAAA, 16'h5555, 1'b0}, 1'b1, 2'd2,
          {18'h0, {16'h5555, 2'b10}, {16'hAAAA, 2'b00}}},
        '{1'b1, 5'd17, {16'h0001, 16'h8000, 1'b1}, 1'b1, 2'd2,
          {18'h0, {16'h8000, 2'b10}, {16'h0001, 2'b00}}},
        '{1'b1, 5'd8,  {16'h12FF, 16'h34FF, 1'b0}, 1'b1, 2'd1,
          {18'h0, 18'h0, {16'h1234, 2'b10}}},
        '{1'b0, 5'd8,  {16'h00FF, 16'hFF00, 1'b0}, 1'b1, 2'd1,
          {18'h0, 18'h0, {16'h00FF, 2'b10}}},
        '{1'b0, 5'd8,  {16'hAB00, 16'hCD00, 1'b1}, 1'b1, 2'd1,
          {18'h0, 18'h0, {16'hABCD, 2'b10}}},
        '{1'b1, 5'd3,  {16'hE000, 16'h2000, 1'b0}, 1'b1, 2'd0, '0},
        '{1'b1, 5'd5,  {16'hF800, 16'h0000, 1'b0}, 1'b0, 2'd0, '0},
        '{1'b0, 5'd5,  {16'hFFFF, 16'hFFFF, 1'b1}, 1'b0, 2'd0, '0},
        '{1'b1, 5'd15, {16'hFFFF, 16'h0000, 1'b0}, 1'b0, 2'd0, '0},
        '{1'b0, 5'd15, {16'h1234, 16'hABCD, 1'b1}, 1'b0, 2'd0, '0},
        '{1'b1, 5'd12, {16'hFFF0, 16'hFFF0, 1'b0}, 1'b0, 2'd0, '0},
        '{1'b0, 5'd12, {16'hABC0, 16'hDEF0, 1'b1}, 1'b0, 2'd0, '0},
        '{1'b1, 5'd16, {16'hFFFF, 16'hFFFF, 1'b1}, 1'b1, 2'd2,
          {18'h0, {16'hFFFF, 2'b10}, {16'hFFFF, 2'b00}}},
        '{1'b0, 5'd16, {16'h0000, 16'h0000, 1'b1}, 1'b1, 2'd2,
          {18'h0, {16'h0000, 2'b10}, {16'h0000, 2'b00}}},
        '{1'b1, 5'd2,  {16'hC000, 16'h4000, 1'b0}, 1'b0, 2'd0, '0},
        '{1'b0, 5'd2,  {16'h8000, 16'h0000, 1'b1}, 1'b0, 2'd0, '0},
        '{1'b1, 5'd4,  {16'hF000, 16'h0000, 1'b0}, 1'b0, 2'd0, '0},
        '{1'b1, 5'd16, {16'h1234, 16'h5678, 1'b1}, 1'b0, 2'd0, '0}
    };

    localparam logic [WIDTH_BITS-1:0] PHASE_WIDTHS [PHASES] =
        '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd12, 5'd15, 5'd5, 5'd3, 5'd9, 5'd17, 5'd8};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [WIDTH_BITS-1:0] cfg_wr_data;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;

    // predictor state
    logic [WIDTH_BITS-1:0] width_cfg;
    logic [31:0]           held_bits;
    int                    held_count;

    out_item_t             words_due [$];
    out_item_t             due_word;
    int                    mismatches;
    int                    gap_pct;
    int                    stall_pct;
    int                    hold_token;

    stereo_sample_bit_packer i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("stereo_sample_bit_packer test failed");
        $finish;
    end

    // Words one request produces; advances the held bits and count.
    function automatic void pack_pair(input in_item_t req,
                                      output out_item_t [MAX_RESULTS-1:0] words,
                                      output int n);
        logic [SAMPLE_BITS-1:0] samples [2];
        logic [31:0]            shifted;
        int                     eff;
        int                     rest;
        words = '0;
        n = 0;
        eff = int'(width_cfg);
        if (eff < 1)
            eff = 1;
        else if (eff > SAMPLE_BITS)
            eff = SAMPLE_BITS;
        samples[0] = req.left_sample;
        samples[1] = req.right_sample;
        for (int s = 0; s < 2; s++)
        begin
            held_bits = (held_bits << eff) | (32'(samples[s]) >> (SAMPLE_BITS - eff));
            held_count += eff;
            while (held_count >= WORD_BITS)
            begin
                rest = held_count - WORD_BITS;
                if (n < MAX_RESULTS)
                begin
                    words[n].packed_word = held_bits[rest +: WORD_BITS];
                    n++;
                end
                held_count = rest;
                held_bits = held_bits & ((32'd1 << rest) - 32'd1);
            end
        end
        if (req.last)
        begin
            // flush the partial word left-aligned, zero padded
            if (held_count > 0 && n < MAX_RESULTS)
            begin
                shifted = held_bits << (WORD_BITS - held_count);
                words[n].packed_word = shifted[WORD_BITS-1:0];
                words[n].stream_end = 1'b1;
                n++;
            end
            held_bits = '0;
            held_count = 0;
        end
        if (n > 0)
            words[n-1].run_last = 1'b1;
    endfunction

    task automatic fault(input string what);
        if (mismatches < REPORT_LIMIT)
            $display("%t: %s", $realtime, what);
        mismatches++;
    endtask

    // Hold the request until accepted, idling first as the sender's mode asks.
    task automatic offer(input in_item_t req);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_width(input logic [WIDTH_BITS-1:0] w);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        width_cfg = w;
    endtask

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin gap_pct = 0;              stall_pct = 0;              end
            IDLE_SENDER:   begin gap_pct = HEAVY_IDLE_PCT; stall_pct = 0;              end
            IDLE_RECEIVER: begin gap_pct = 0;              stall_pct = HEAVY_IDLE_PCT; end
            default:       begin gap_pct = BOTH_IDLE_PCT;  stall_pct = BOTH_IDLE_PCT;  end
        endcase
    endtask

    // Receiver: random stalls, and a long hold-off each time the token advances.
    initial
    begin
        int hold_seen;
        hold_seen = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_token != hold_seen)
            begin
                hold_seen = hold_token;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (words_due.size() == 0)
                fault($sformatf("unexpected word %h run_last %b stream_end %b",
                                out_data.packed_word, out_data.run_last,
                                out_data.stream_end));
            else
            begin
                due_word = words_due.pop_front();
                if (out_data.packed_word !== due_word.packed_word
                    || out_data.run_last !== due_word.run_last
                    || out_data.stream_end !== due_word.stream_end)
                    fault($sformatf("expected %h/%b/%b, got %h/%b/%b",
                                    due_word.packed_word, due_word.run_last,
                                    due_word.stream_end, out_data.packed_word,
                                    out_data.run_last, out_data.stream_end));
            end
        end
    end

    initial
    begin
        out_item_t [MAX_RESULTS-1:0] words;
        int                          n;
        in_item_t                    req;
        pair_case_t                  row;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        mismatches = 0;
        hold_token = 0;
        gap_pct = 0;
        stall_pct = 0;
        width_cfg = WIDTH_RESET;
        held_bits = '0;
        held_count = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(PAIR_CASES); i++)
        begin
            row = PAIR_CASES[i];
            if (row.wr)
                program_width(row.width);
            offer(row.item);
            pack_pair(row.item, words, n);
            if (row.typed)
            begin
                for (int k = 0; k < int'(row.n_typed); k++)
                    words_due.push_back(row.want[k]);
            end
            else
            begin
                for (int k = 0; k < n; k++)
                    words_due.push_back(words[k]);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            program_width(PHASE_WIDTHS[p]);
            set_idling(idle_mode_t'(p % 4));
            // block the output so the packer fills up and stalls its input
            if (p == 0)
                hold_token = hold_token + 1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 5 && i == 7)
                    drain();
                req.left_sample = 16'($urandom_range(16'hFFFF));
                req.right_sample = 16'($urandom_range(16'hFFFF));
                req.last = ($urandom_range(5) == 0);
                offer(req);
                pack_pair(req, words, n);
                for (int k = 0; k < n; k++)
                    words_due.push_back(words[k]);
            end
        end

        drain();
        if (mismatches == 0 && words_due.size() == 0)
            $display("stereo_sample_bit_packer test passed");
        else
            $display("stereo_sample_bit_packer test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sbp_pkg.sv
hdl/sbp_pack.sv
hdl/sbp_out_buf.sv
hdl/stereo_sample_bit_packer.sv
hdl/sbp_checker.sv
tb/stereo_sample_bit_packer_tb.sv
